>>> rtl/rgbads_pkg.sv
// Shared constants, register codes and types for the RGB area-average line downscaler.
// No dependencies; every other file in rtl/ imports this package.
package rgbads_pkg;

   // Parameter defaults and legal limits
   localparam int unsigned MAX_LINE_DEF      = 4096;
   localparam int unsigned FRACTION_BITS_DEF = 16;
   localparam int unsigned FRACTION_BITS_MAX = 24;

   // Fixed field and register widths
   localparam int unsigned COLOR_W    = 8;
   localparam int unsigned SUM_W      = 32;
   localparam int unsigned RATIO_W    = 24;
   localparam int unsigned INV_W      = 17;
   localparam int unsigned OPL_W      = 13;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 24;
   // Weight fields in the lane control word are sized for the widest fraction
   localparam int unsigned LANE_WT_W  = FRACTION_BITS_MAX + 1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_RATIO   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INVERSE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUTS = 2'd2;

   // Register reset values
   localparam logic [RATIO_W-1:0] RATIO_RST   = 24'd65536;
   localparam logic [INV_W-1:0]   INVERSE_RST = 17'd65536;
   localparam logic [OPL_W-1:0]   OUTPUTS_RST = 13'd1;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD
   } state_type;

   // Control word from the sequencer to each channel lane
   typedef struct packed {
      logic                 accept;
      logic                 clear;
      logic                 split;
      logic [LANE_WT_W-1:0] w_used;
      logic [LANE_WT_W-1:0] rest;
      logic [INV_W-1:0]     inv;
      logic                 mul_en;
      logic                 sel;
   } lane_ctrl_type;

   // Control word from the sequencer to the output merge register
   typedef struct packed {
      logic load;
      logic run_end;
   } out_ctrl_type;

endpackage

>>> rtl/rgbads_lane.sv
// One color channel lane: weighted accumulator, result holding slots and a two-stage
// scaler (split partial products, then round, shift and saturate). Uses rgbads_pkg.
module rgbads_lane #(
   parameter int unsigned FRACTION_BITS = rgbads_pkg::FRACTION_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  rgbads_pkg::lane_ctrl_type          ctrl,
   input  logic [rgbads_pkg::COLOR_W-1:0]     pixel,
   output logic [rgbads_pkg::COLOR_W-1:0]     value
);
   import rgbads_pkg::*;

   localparam int unsigned PROD_W = SUM_W + 1;
   localparam int unsigned PART_W = SUM_W / 2;
   localparam int unsigned MUL_W  = PART_W + INV_W;
   localparam int unsigned FULL_W = SUM_W + INV_W + 1;

   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic [SUM_W-1:0]  pend0_ff, pend1_ff;
   logic [MUL_W-1:0]  prod_lo_ff, prod_hi_ff;
   logic [PROD_W-1:0] add_prod, rest_prod, add_sum;
   logic [SUM_W-1:0]  add_sat;
   logic [SUM_W-1:0]  mul_src;
   logic [FULL_W-1:0] full, scaled;

   // Weight this pixel into the running sum, saturating at full scale
   assign add_prod  = PROD_W'(pixel) * PROD_W'(ctrl.w_used[FRACTION_BITS:0]);
   assign rest_prod = PROD_W'(pixel) * PROD_W'(ctrl.rest[FRACTION_BITS:0]);
   assign add_sum   = {1'b0, acc_ff} + add_prod;
   assign add_sat   = add_sum[SUM_W] ? {SUM_W{1'b1}} : add_sum[SUM_W-1:0];

   // Restart, start the next sum from the split rest, or keep accumulating
   always_comb begin
      acc_in = acc_ff;
      priority if (ctrl.clear) begin
         acc_in = '0;
      end else if (ctrl.accept) begin
         acc_in = ctrl.split ? rest_prod[SUM_W-1:0] : add_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // Hold the finished sum and the trailing sum until scaled
   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         pend0_ff <= add_sat;
         pend1_ff <= rest_prod[SUM_W-1:0];
      end
   end

   // Scaler stage one: partial products of the two sum halves
   assign mul_src = ctrl.sel ? pend1_ff : pend0_ff;

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_lo_ff <= MUL_W'(mul_src[PART_W-1:0]) * MUL_W'(ctrl.inv);
         prod_hi_ff <= MUL_W'(mul_src[SUM_W-1:PART_W]) * MUL_W'(ctrl.inv);
      end
   end

   // Scaler stage two: combine, round by one half, drop the fraction, saturate
   assign full   = (FULL_W'(prod_hi_ff) << PART_W) + FULL_W'(prod_lo_ff)
                 + (FULL_W'(1) << (2 * FRACTION_BITS - 1));
   assign scaled = full >> (2 * FRACTION_BITS);
   assign value  = (scaled > FULL_W'(255)) ? {COLOR_W{1'b1}} : scaled[COLOR_W-1:0];

endmodule

>>> rtl/rgbads_ctrl.sv
// Sequencer: configuration registers, remaining weight, output count and the
// result state machine that drives the lanes and the merge register. Uses rgbads_pkg.
module rgbads_ctrl #(
   parameter int unsigned MAX_LINE      = rgbads_pkg::MAX_LINE_DEF,
   parameter int unsigned FRACTION_BITS = rgbads_pkg::FRACTION_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_line_end,
   output logic                                req_stall,
   input  logic                                csr_write,
   input  logic [rgbads_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rgbads_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                                out_free,
   output rgbads_pkg::lane_ctrl_type           lane_ctrl,
   output rgbads_pkg::out_ctrl_type            out_ctrl
);
   import rgbads_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_LINE + 1);
   localparam int unsigned WT_W  = (FRACTION_BITS + 2 > RATIO_W + 1) ?
                                   FRACTION_BITS + 2 : RATIO_W + 1;
   localparam int unsigned CMP_W = (CNT_W > OPL_W) ? CNT_W : OPL_W;
   localparam logic [WT_W-1:0] ONE_WT  = WT_W'(1) << FRACTION_BITS;
   localparam logic [WT_W-1:0] HALF_WT = WT_W'(1) << (FRACTION_BITS - 1);
   localparam logic [WT_W-1:0] WT_RST  = (WT_W'(RATIO_RST) < ONE_WT) ?
                                         ONE_WT : WT_W'(RATIO_RST);

   logic [RATIO_W-1:0] ratio_ff, ratio_in;
   logic [INV_W-1:0]   inv_ff, inv_in;
   logic [OPL_W-1:0]   opl_ff, opl_in;
   logic [WT_W-1:0]    weight_ff, weight_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [1:0]         pend_n_ff, pend_n_in;
   logic               idx_ff, idx_in;
   state_type          state_ff, state_in;

   logic               accept, cfg_ratio, split, trail, run_last;
   logic [WT_W-1:0]    eff, eff_new, rest, w_used, wl_a;
   logic [CNT_W-1:0]   cnt_inc, cnt_a;
   logic [1:0]         n_res;

   // Effective ratio never below one
   assign eff     = (WT_W'(ratio_ff) < ONE_WT) ? ONE_WT : WT_W'(ratio_ff);
   assign eff_new = (WT_W'(csr_data[RATIO_W-1:0]) < ONE_WT) ?
                    ONE_WT : WT_W'(csr_data[RATIO_W-1:0]);

   // Weight bookkeeping for the pixel being taken
   assign accept    = (state_ff == ST_IDLE) && req_valid;
   assign cfg_ratio = csr_write && (csr_index == REG_RATIO);
   assign split     = (weight_ff <= ONE_WT);
   assign rest      = ONE_WT - weight_ff;
   assign w_used    = split ? weight_ff : ONE_WT;
   assign wl_a      = split ? (eff - rest) : (weight_ff - ONE_WT);
   assign cnt_inc   = (cnt_ff < CNT_W'(MAX_LINE)) ? cnt_ff + 1'b1 : cnt_ff;
   assign cnt_a     = split ? cnt_inc : cnt_ff;
   assign trail     = req_line_end && (wl_a < HALF_WT) &&
                      (CMP_W'(cnt_a) < CMP_W'(opl_ff));
   assign n_res     = 2'(split) + 2'(trail);
   assign run_last  = (2'(idx_ff) + 2'd1 == pend_n_ff);

   // Configuration and line state
   always_comb begin
      ratio_in  = ratio_ff;
      inv_in    = inv_ff;
      opl_in    = opl_ff;
      weight_in = weight_ff;
      cnt_in    = cnt_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_RATIO:   ratio_in = csr_data[RATIO_W-1:0];
            REG_INVERSE: inv_in   = csr_data[INV_W-1:0];
            REG_OUTPUTS: opl_in   = csr_data[OPL_W-1:0];
            default:     ;
         endcase
      end
      priority if (cfg_ratio) begin
         weight_in = eff_new;
         cnt_in    = '0;
      end else if (accept) begin
         weight_in = req_line_end ? eff : wl_a;
         cnt_in    = req_line_end ? '0 : cnt_a;
      end
   end

   // Result bookkeeping: how many results, which one is next
   always_comb begin
      pend_n_in = pend_n_ff;
      idx_in    = idx_ff;
      priority if (accept) begin
         pend_n_in = n_res;
         idx_in    = 1'b0;
      end else if ((state_ff == ST_ADD) && out_free) begin
         idx_in = ~idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff  <= RATIO_RST;
         inv_ff    <= INVERSE_RST;
         opl_ff    <= OUTPUTS_RST;
         weight_ff <= WT_RST;
         cnt_ff    <= '0;
         pend_n_ff <= '0;
         idx_ff    <= 1'b0;
         state_ff  <= ST_IDLE;
      end else begin
         ratio_ff  <= ratio_in;
         inv_ff    <= inv_in;
         opl_ff    <= opl_in;
         weight_ff <= weight_in;
         cnt_ff    <= cnt_in;
         pend_n_ff <= pend_n_in;
         idx_ff    <= idx_in;
         state_ff  <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept && (n_res != 2'd0)) state_in = ST_MUL;
         ST_MUL:  state_in = ST_ADD;
         ST_ADD: begin
            if (out_free) state_in = run_last ? ST_IDLE : ST_MUL;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_stall        = (state_ff != ST_IDLE);
      lane_ctrl.accept = accept;
      lane_ctrl.clear  = cfg_ratio || (accept && req_line_end);
      lane_ctrl.split  = split;
      lane_ctrl.w_used = LANE_WT_W'(w_used[FRACTION_BITS:0]);
      lane_ctrl.rest   = LANE_WT_W'(rest[FRACTION_BITS:0]);
      lane_ctrl.inv    = inv_ff;
      lane_ctrl.mul_en = (state_ff == ST_MUL);
      lane_ctrl.sel    = idx_ff;
      out_ctrl.load    = (state_ff == ST_ADD) && out_free;
      out_ctrl.run_end = run_last;
   end

endmodule

>>> rtl/rgb_area_average_downsample_line.sv
// Top level of the RGB area-average line downscaler: sequencer, three channel
// lanes and the merge register that forms each result. Uses rgbads_pkg.
//
//   channel | ports              | flow  | transfer when
//   req     | req_* source pixel | in    | req_valid && !req_stall
//   rsp     | rsp_* output pixel | out   | rsp_valid && !rsp_stall
//   csr     | csr_* write port   | in    | csr_write
//
// A pixel that yields no result is taken without a stall; one that yields n results (up to
// two) holds req_stall while each result passes the two scaler stages into the output register.
// Reset is synchronous and leaves no clearing pass; the block is ready at once.
// A new pixel is taken while the last result still waits in the output register;
// rsp_stall holds the scaler only when that register is still full.
module rgb_area_average_downsample_line #(
   parameter int unsigned MAX_LINE      = rgbads_pkg::MAX_LINE_DEF,
   parameter int unsigned FRACTION_BITS = rgbads_pkg::FRACTION_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rgbads_pkg::COLOR_W-1:0]      req_red_in,
   input  logic [rgbads_pkg::COLOR_W-1:0]      req_green_in,
   input  logic [rgbads_pkg::COLOR_W-1:0]      req_blue_in,
   input  logic                                req_line_end,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rgbads_pkg::COLOR_W-1:0]      rsp_red_out,
   output logic [rgbads_pkg::COLOR_W-1:0]      rsp_green_out,
   output logic [rgbads_pkg::COLOR_W-1:0]      rsp_blue_out,
   output logic                                rsp_run_end,
   input  logic                                csr_write,
   input  logic [rgbads_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rgbads_pkg::CSR_DATA_W-1:0]   csr_data
);
   import rgbads_pkg::*;

   lane_ctrl_type      lane_ctrl;
   out_ctrl_type       out_ctrl;
   logic               out_free;
   logic [COLOR_W-1:0] red_val, green_val, blue_val;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0] red_ff, green_ff, blue_ff;
   logic               run_end_ff;

   rgbads_ctrl #(
      .MAX_LINE      (MAX_LINE),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_line_end (req_line_end),
      .req_stall    (req_stall),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .out_free     (out_free),
      .lane_ctrl    (lane_ctrl),
      .out_ctrl     (out_ctrl)
   );

   rgbads_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_red (
      .clock (clock),
      .reset (reset),
      .ctrl  (lane_ctrl),
      .pixel (req_red_in),
      .value (red_val)
   );

   rgbads_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_green (
      .clock (clock),
      .reset (reset),
      .ctrl  (lane_ctrl),
      .pixel (req_green_in),
      .value (green_val)
   );

   rgbads_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_blue (
      .clock (clock),
      .reset (reset),
      .ctrl  (lane_ctrl),
      .pixel (req_blue_in),
      .value (blue_val)
   );

   // Merge the three lane values into one result; hold it while stalled
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = out_ctrl.load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ctrl.load) begin
         red_ff     <= red_val;
         green_ff   <= green_val;
         blue_ff    <= blue_val;
         run_end_ff <= out_ctrl.run_end;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;
   assign rsp_run_end   = run_end_ff;

endmodule

>>> sim/tb_rgb_area_average_downsample_line.sv
// Self-checking bench for the RGB area-average line downscaler: a directed table, then random
// lines under varying handshake pressure, every result checked against a given value or a cycle-free predictor.
// Depends on rtl/rgbads_pkg.sv and rtl/rgb_area_average_downsample_line.sv.
`timescale 1ns / 1ps

module tb_rgb_area_average_downsample_line;
   import rgbads_pkg::*;

   localparam int unsigned FB          = FRACTION_BITS_DEF;
   localparam logic [63:0] ONE_W       = 64'd1 << FB;
   localparam logic [63:0] HALF_W      = ONE_W >> 1;
   localparam logic [63:0] SUM_CAP     = 64'hFFFF_FFFF;
   localparam int unsigned RANDOM_ITEMS = 1250;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 8;
   // Index that maps to no register
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic               line_end;
   } pixel_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic               run_end;
   } out_pixel_type;

   typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_data;
      pixel_type             pix;
      logic                  typed;
      out_pixel_type         want;
   } row_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [COLOR_W-1:0]    req_red_in = '0;
   logic [COLOR_W-1:0]    req_green_in = '0;
   logic [COLOR_W-1:0]    req_blue_in = '0;
   logic                  req_line_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [COLOR_W-1:0]    rsp_red_out;
   logic [COLOR_W-1:0]    rsp_green_out;
   logic [COLOR_W-1:0]    rsp_blue_out;
   logic                  rsp_run_end;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Handshake pressure, in percent of cycles
   int unsigned send_gap_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned err_count = 0;
   int unsigned cycle_count = 0;

   // Predictor copy of registers and line state
   logic [RATIO_W-1:0] ratio_reg;
   logic [INV_W-1:0]   inv_reg;
   logic [OPL_W-1:0]   opl_reg;
   logic [24:0]        weight_left;
   logic [SUM_W-1:0]   sums [3];
   logic [OPL_W-1:0]   out_count;

   out_pixel_type expected_pixels [$];
   out_pixel_type step_results [$];
   row_type       directed_rows [$];

   rgb_area_average_downsample_line dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_red_in   (req_red_in),
      .req_green_in (req_green_in),
      .req_blue_in  (req_blue_in),
      .req_line_end (req_line_end),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_red_out  (rsp_red_out),
      .rsp_green_out(rsp_green_out),
      .rsp_blue_out (rsp_blue_out),
      .rsp_run_end  (rsp_run_end),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic [63:0] eff_ratio();
      return (ratio_reg < ONE_W) ? ONE_W : {40'd0, ratio_reg};
   endfunction

   function automatic void restart_line();
      weight_left = 25'(eff_ratio());
      sums[0] = '0;
      sums[1] = '0;
      sums[2] = '0;
      out_count = '0;
   endfunction

   function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a, logic [63:0] b);
      logic [63:0] s;
      s = {32'd0, a} + b;
      return (s > SUM_CAP) ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic logic [COLOR_W-1:0] scale_sum(logic [SUM_W-1:0] s);
      logic [63:0] v;
      v = ({32'd0, s} * {47'd0, inv_reg} + (64'd1 << (2 * FB - 1))) >> (2 * FB);
      return (v > 64'd255) ? 8'hFF : v[7:0];
   endfunction

   // Scale the current sums into one result and count it
   function automatic out_pixel_type emit_sum();
      out_pixel_type o;
      o.red = scale_sum(sums[0]);
      o.green = scale_sum(sums[1]);
      o.blue = scale_sum(sums[2]);
      o.run_end = 1'b0;
      if (out_count < MAX_LINE_DEF) out_count++;
      return o;
   endfunction

   // Accumulate one source pixel; results land in step_results
   function automatic void downscale_step(pixel_type p);
      logic [63:0] px [3];
      logic [63:0] rest;
      px[0] = {56'd0, p.red};
      px[1] = {56'd0, p.green};
      px[2] = {56'd0, p.blue};
      step_results = {};
      if ({39'd0, weight_left} > ONE_W) begin
         for (int c = 0; c < 3; c++) sums[c] = sat_add(sums[c], px[c] * ONE_W);
         weight_left = weight_left - ONE_W[24:0];
      end else begin
         // split the pixel: finish this output, carry the rest into the next
         rest = ONE_W - {39'd0, weight_left};
         for (int c = 0; c < 3; c++) sums[c] = sat_add(sums[c], px[c] * {39'd0, weight_left});
         step_results.push_back(emit_sum());
         for (int c = 0; c < 3; c++) sums[c] = 32'(px[c] * rest);
         weight_left = 25'(eff_ratio() - rest);
      end
      if (p.line_end) begin
         if ({39'd0, weight_left} < HALF_W && out_count < opl_reg)
            step_results.push_back(emit_sum());
         restart_line();
      end
      if (step_results.size() > 0) step_results[step_results.size() - 1].run_end = 1'b1;
   endfunction

   // ---------------------------------------------------------------- drivers
   task automatic send_pixel(input pixel_type p, input logic typed, input out_pixel_type want);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red_in <= p.red;
      req_green_in <= p.green;
      req_blue_in <= p.blue;
      req_line_end <= p.line_end;
      do @(posedge clock); while (req_stall);
      // transfer taken at this edge
      downscale_step(p);
      if (typed) expected_pixels.push_back(want);
      else foreach (step_results[i]) expected_pixels.push_back(step_results[i]);
   endtask

   // Drop valid, drain all outstanding results, then let the pipeline settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      case (idx)
         REG_RATIO: begin
            ratio_reg = data[RATIO_W-1:0];
            restart_line();
         end
         REG_INVERSE: inv_reg = data[INV_W-1:0];
         REG_OUTPUTS: opl_reg = data[OPL_W-1:0];
         default: ;
      endcase
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void add_row(row_kind_type kind, logic [CSR_IDX_W-1:0] idx,
                                   logic [CSR_DATA_W-1:0] data, pixel_type pix,
                                   logic typed, out_pixel_type want);
      row_type r;
      r.kind = kind;
      r.reg_idx = idx;
      r.reg_data = data;
      r.pix = pix;
      r.typed = typed;
      r.want = want;
      directed_rows.push_back(r);
   endfunction

   function automatic logic [COLOR_W-1:0] pick_level();
      if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      return 8'($urandom_range(0, 255));
   endfunction

   // ---------------------------------------------------------------- receiver
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin : check_rsp
      out_pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected result transfer: red %0d green %0d blue %0d run_end %0d",
                   rsp_red_out, rsp_green_out, rsp_blue_out, rsp_run_end);
            err_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_red_out !== want.red) begin
               $error("red_out: expected %0d, actual %0d", want.red, rsp_red_out);
               err_count++;
            end
            if (rsp_green_out !== want.green) begin
               $error("green_out: expected %0d, actual %0d", want.green, rsp_green_out);
               err_count++;
            end
            if (rsp_blue_out !== want.blue) begin
               $error("blue_out: expected %0d, actual %0d", want.blue, rsp_blue_out);
               err_count++;
            end
            if (rsp_run_end !== want.run_end) begin
               $error("run_end: expected %0d, actual %0d", want.run_end, rsp_run_end);
               err_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_rgb_area_average_downsample_line: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus
   initial begin
      pixel_type       p;
      int unsigned     items_sent;
      int unsigned     phase_num;
      int unsigned     phase_items;
      int unsigned     line_len;
      int unsigned     cur_len;
      int unsigned     line_pos;
      int unsigned     new_ratio;
      int unsigned     eff;
      int unsigned     pick;
      longint unsigned recip;
      int              inv_val;
      int              opl_val;
      logic            large_phase;

      ratio_reg = RATIO_RST;
      inv_reg = INVERSE_RST;
      opl_reg = OUTPUTS_RST;
      restart_line();

      // Unity ratio passes pixels straight through; large inverse saturates
      add_row(ROW_PIXEL, REG_RATIO, '0, {8'd255, 8'd0, 8'd255, 1'b0}, 1'b1,
              {8'd255, 8'd0, 8'd255, 1'b1});
      add_row(ROW_PIXEL, REG_RATIO, '0, {8'd0, 8'd255, 8'd0, 1'b1}, 1'b1,
              {8'd0, 8'd255, 8'd0, 1'b1});
      add_row(ROW_PIXEL, REG_RATIO, '0, {8'h55, 8'hAA, 8'h0F, 1'b0}, 1'b1,
              {8'h55, 8'hAA, 8'h0F, 1'b1});
      add_row(ROW_PIXEL, REG_RATIO, '0, {8'hAA, 8'h55, 8'hF0, 1'b1}, 1'b1,
              {8'hAA, 8'h55, 8'hF0, 1'b1});
      add_row(ROW_WRITE, REG_INVERSE, 24'd131071, '0, 1'b0, '0);
      add_row(ROW_PIXEL, REG_RATIO, '0, {8'd200, 8'd1, 8'd0, 1'b0}, 1'b1,
              {8'd255, 8'd2, 8'd0, 1'b1});
      add_row(ROW_PIXEL, REG_RATIO, '0, {8'd255, 8'd255, 8'd255, 1'b1}, 1'b1,
              {8'd255, 8'd255, 8'd255, 1'b1});
      add_row(ROW_WRITE, REG_INVERSE, 24'd65536, '0, 1'b0, '0);
      // ratio below one acts as unity
      add_row(ROW_WRITE, REG_RATIO, 24'd0, '0, 1'b0, '0);
      add_row(ROW_PIXEL, REG_RATIO, '0, {8'd17, 8'd34, 8'd51, 1'b1}, 1'b1,
              {8'd17, 8'd34, 8'd51, 1'b1});
      // fractional ratio with splits
      add_row(ROW_WRITE, REG_RATIO, 24'd98304, '0, 1'b0, '0);
      add_row(ROW_WRITE, REG_INVERSE, 24'd43691, '0, 1'b0, '0);
      add_row(ROW_WRITE, REG_OUTPUTS, 24'd2, '0, 1'b0, '0);
      add_row(ROW_PIXEL, REG_RATIO, '0, {8'd10, 8'd20, 8'd30, 1'b0}, 1'b0, '0);
      add_row(ROW_PIXEL, REG_RATIO, '0, {8'd40, 8'd50, 8'd60, 1'b0}, 1'b0, '0);
      add_row(ROW_PIXEL, REG_RATIO, '0, {8'd70, 8'd80, 8'd90, 1'b0}, 1'b0, '0);
      add_row(ROW_PIXEL, REG_RATIO, '0, {8'd100, 8'd110, 8'd120, 1'b1}, 1'b0, '0);
      // trailing partial output held back by a zero outputs-per-line setting, then let through
      add_row(ROW_WRITE, REG_RATIO, 24'd81920, '0, 1'b0, '0);
      add_row(ROW_WRITE, REG_INVERSE, 24'd52429, '0, 1'b0, '0);
      add_row(ROW_WRITE, REG_OUTPUTS, 24'd0, '0, 1'b0, '0);
      add_row(ROW_PIXEL, REG_RATIO, '0, {8'd9, 8'd200, 8'd77, 1'b1}, 1'b0, '0);
      add_row(ROW_WRITE, REG_OUTPUTS, 24'd8191, '0, 1'b0, '0);
      add_row(ROW_PIXEL, REG_RATIO, '0, {8'd9, 8'd200, 8'd77, 1'b1}, 1'b0, '0);
      add_row(ROW_WRITE, REG_UNUSED, 24'hFFFFFF, '0, 1'b0, '0);
      add_row(ROW_PIXEL, REG_RATIO, '0, {8'd1, 8'd2, 8'd3, 1'b1}, 1'b0, '0);
      // widest ratio, a small inverse
      add_row(ROW_WRITE, REG_RATIO, 24'hFFFFFF, '0, 1'b0, '0);
      add_row(ROW_WRITE, REG_INVERSE, 24'd256, '0, 1'b0, '0);
      add_row(ROW_PIXEL, REG_RATIO, '0, {8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, '0);
      add_row(ROW_PIXEL, REG_RATIO, '0, {8'd0, 8'd0, 8'd0, 1'b1}, 1'b0, '0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed rows
      send_gap_pct = 36;
      stall_pct = 66;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            wait_idle();
            write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
         end else begin
            send_pixel(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].want);
         end
      end

      // Random phases: new settings, then a run of lines
      items_sent = 0;
      phase_num = 0;
      line_pos = 0;
      while (items_sent < RANDOM_ITEMS) begin
         phase_num++;
         wait_idle();
         large_phase = (phase_num == 2) || ($urandom_range(0, 29) == 0);
         if (large_phase) begin
            new_ratio = (phase_num == 2) ? 32'hFF_FFFF : $urandom_range(32'h40_0000, 32'hFF_FFFF);
            line_len = (new_ratio >> 16) + $urandom_range(0, 4);
            phase_items = line_len + $urandom_range(0, line_len / 2);
         end else begin
            pick = $urandom_range(0, 9);
            if (pick == 0) new_ratio = $urandom_range(0, 65535);
            else if (pick <= 2) new_ratio = 65536 * $urandom_range(1, 4);
            else new_ratio = $urandom_range(65536, 4 * 65536);
            line_len = $urandom_range(1, 24);
            phase_items = $urandom_range(20, 80);
         end
         eff = (new_ratio < 65536) ? 65536 : new_ratio;

         // skip the ratio write now and then so the line carries over
         if (large_phase || $urandom_range(0, 3) != 0) begin
            write_reg(REG_RATIO, new_ratio[CSR_DATA_W-1:0]);
            line_pos = 0;
         end

         pick = $urandom_range(0, 9);
         if (pick == 0) inv_val = int'($urandom_range(0, 131071));
         else if (pick == 1) inv_val = 131071;
         else begin
            recip = 64'h1_0000_0000 / eff;
            inv_val = int'(recip) + int'($urandom_range(0, 4)) - 2;
         end
         if (inv_val > 131071) inv_val = 131071;
         if (inv_val < 0) inv_val = 0;
         write_reg(REG_INVERSE, CSR_DATA_W'(($urandom_range(0, 127) << INV_W) | inv_val));

         pick = $urandom_range(0, 9);
         if (pick == 0) opl_val = 0;
         else if (pick == 1) opl_val = int'($urandom_range(0, 8191));
         else opl_val = int'((line_len * 65536) / eff) + int'($urandom_range(0, 2)) - 1;
         if (opl_val < 0) opl_val = 0;
         write_reg(REG_OUTPUTS, CSR_DATA_W'(($urandom_range(0, 2047) << OPL_W) | opl_val));

         if ($urandom_range(0, 7) == 0)
            write_reg(REG_UNUSED, CSR_DATA_W'($urandom_range(0, 32'hFF_FFFF)));

         cur_len = line_len;
         for (int k = 0; k < phase_items; k++) begin
            if (items_sent < RANDOM_ITEMS / 3) begin
               send_gap_pct = 36;
               stall_pct = 66;
            end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
               send_gap_pct = 66;
               stall_pct = 36;
            end else begin
               send_gap_pct = 0;
               stall_pct = 0;
            end
            p.red = pick_level();
            p.green = pick_level();
            p.blue = pick_level();
            // mostly full lines, with the odd early end as noise
            p.line_end = (line_pos + 1 >= cur_len) || ($urandom_range(0, 49) == 0);
            if (p.line_end) begin
               line_pos = 0;
               cur_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : line_len;
            end else begin
               line_pos++;
            end
            send_pixel(p, 1'b0, '0);
            items_sent++;
         end
      end

      wait_idle();
      repeat (12) @(posedge clock);
      if (err_count == 0) $display("tb_rgb_area_average_downsample_line: done, clean");
      else $display("tb_rgb_area_average_downsample_line: done, errors");
      $finish;
   end

endmodule
